// File: hdl/smooth_2p3q_sequence_generator_defines.svh
// Assertion macros for the 3-smooth sequence generator.
// Depends on nothing; included by s23sg_back, the one module that carries assertions.
// The checking forms are dropped when SYNTHESIS is defined.
`ifndef SMOOTH_2P3Q_SEQUENCE_GENERATOR_DEFINES_SVH
`define SMOOTH_2P3Q_SEQUENCE_GENERATOR_DEFINES_SVH

`ifndef SYNTHESIS
`define S23SG_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define S23SG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define S23SG_ASSERT_SAME(label, ante, cons, msg)
`define S23SG_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// File: hdl/s23sg_pkg.sv
// Shared constants and types for the 3-smooth sequence generator.
// Depends on nothing; imported by every module of the block.
package s23sg_pkg;

  localparam int unsigned DefaultStoreDepth = 64;
  localparam int unsigned LimitWidth        = 13;
  localparam int unsigned ValueWidth        = 12;
  localparam int unsigned QueueDepth        = 2;

  localparam logic [LimitWidth-1:0] LimitCap   = 13'd4096;
  localparam logic [LimitWidth-1:0] SingleMax  = 13'd2;
  localparam logic [ValueWidth-1:0] FirstValue = 12'd1;

  typedef struct packed {
    logic [LimitWidth-1:0] lim;
    logic                  single;
  } job_t;

endpackage

// File: hdl/smooth_2p3q_sequence_generator.sv
// Top level of the 3-smooth (2^p * 3^q) sequence generator.
// Depends on s23sg_pkg, s23sg_front, s23sg_queue and s23sg_back.
//
//  Channel   Direction  Handshake             Payload
//  request   in         start && !busy        limit_i
//  result    out        strobe_o (no stall)   value_o, last_o
//
// A request first sets up the store, then gives its values in ascending order, up to 55 of them.
// The merge engine produces one value per cycle from its store's two read ports.
// A request with a limit of two or less skips the merge run and gives only the value 1.
// Up to two requests wait in a queue; busy is high while it is full.
// Reset is asynchronous and active low; the value store is not cleared.
module smooth_2p3q_sequence_generator
  import s23sg_pkg::*;
#(
  parameter int unsigned STORE_DEPTH = DefaultStoreDepth
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [LimitWidth-1:0] limit_i,
  output logic [ValueWidth-1:0] value_o,
  output logic                  last_o,
  output logic                  strobe_o
);

  logic push, queue_full, job_valid, job_pop;
  job_t job_in, job_head;

  s23sg_front u_front (
    .start        (start),
    .busy         (busy),
    .limit_i      (limit_i),
    .queue_full_i (queue_full),
    .push_o       (push),
    .job_o        (job_in)
  );

  s23sg_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .pop_i   (job_pop),
    .full_o  (queue_full),
    .valid_o (job_valid),
    .job_o   (job_head)
  );

  s23sg_back #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (job_head),
    .job_pop_o   (job_pop),
    .value_o     (value_o),
    .last_o      (last_o),
    .strobe_o    (strobe_o)
  );

endmodule

// File: hdl/s23sg_front.sv
// Front end: takes requests, saturates the limit and marks trivial requests.
// Depends on s23sg_pkg.
module s23sg_front
  import s23sg_pkg::*;
(
  input  logic                  start,
  output logic                  busy,
  input  logic [LimitWidth-1:0] limit_i,
  input  logic                  queue_full_i,
  output logic                  push_o,
  output job_t                  job_o
);

  assign busy   = queue_full_i;
  assign push_o = start && !queue_full_i;

  always_comb begin
    job_o.lim    = (limit_i > LimitCap) ? LimitCap : limit_i;
    job_o.single = (limit_i <= SingleMax);
  end

endmodule

// File: hdl/s23sg_queue.sv
// Short request queue between the front end and the merge engine.
// Depends on s23sg_pkg.
module s23sg_queue
  import s23sg_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  input  logic pop_i,
  output logic full_o,
  output logic valid_o,
  output job_t job_o
);

  localparam int unsigned PtrWidth = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntWidth = $clog2(QueueDepth + 1);

  job_t                entry_q [QueueDepth];
  logic [PtrWidth-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntWidth-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntWidth'(QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign job_o   = entry_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrWidth'(QueueDepth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrWidth'(QueueDepth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_q] <= job_i;
    end
  end

endmodule

// File: hdl/s23sg_back.sv
// Merge engine: two-pointer merge over a store of the values produced so far.
// Depends on s23sg_pkg and the assertion macros header.
`include "smooth_2p3q_sequence_generator_defines.svh"
module s23sg_back
  import s23sg_pkg::*;
#(
  parameter int unsigned STORE_DEPTH = DefaultStoreDepth
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  job_valid_i,
  input  job_t                  job_i,
  output logic                  job_pop_o,
  output logic [ValueWidth-1:0] value_o,
  output logic                  last_o,
  output logic                  strobe_o
);

  localparam int unsigned AddrWidth = $clog2(STORE_DEPTH);
  localparam int unsigned CntWidth  = $clog2(STORE_DEPTH + 1);

  typedef enum logic [1:0] {
    BackIdle = 2'b01,
    BackRun  = 2'b10
  } back_state_e;

  back_state_e state_q, state_d;

  logic [ValueWidth-1:0] store_q [STORE_DEPTH];
  logic [ValueWidth-1:0] rd2_q, rd3_q;
  logic [ValueWidth-1:0] pend_q, pend_d;
  logic [LimitWidth-1:0] lim_q, lim_d;
  logic [AddrWidth-1:0]  dp_q, dp_d, tp_q, tp_d;
  logic [CntWidth-1:0]   wi_q, wi_d;
  logic                  strobe_q, strobe_d;
  logic [ValueWidth-1:0] value_q, value_d;
  logic                  last_q, last_d;

  logic                  mem_we;
  logic [AddrWidth-1:0]  mem_waddr;
  logic [ValueWidth-1:0] mem_wdata;

  logic [ValueWidth:0]   cand2;
  logic [ValueWidth+1:0] cand3;
  logic [ValueWidth+1:0] nxt;
  logic                  stop;

  assign job_pop_o = (state_q == BackIdle) && job_valid_i;

  always_comb begin
    cand2 = {rd2_q, 1'b0};
    cand3 = {1'b0, rd3_q, 1'b0} + {2'b00, rd3_q};
    nxt   = ({1'b0, cand2} <= cand3) ? {1'b0, cand2} : cand3;
    stop  = (nxt >= {1'b0, lim_q}) || (wi_q == CntWidth'(STORE_DEPTH));
  end

  always_comb begin
    state_d   = state_q;
    pend_d    = pend_q;
    lim_d     = lim_q;
    dp_d      = dp_q;
    tp_d      = tp_q;
    wi_d      = wi_q;
    strobe_d  = 1'b0;
    value_d   = value_q;
    last_d    = last_q;
    mem_we    = 1'b0;
    mem_waddr = wi_q[AddrWidth-1:0];
    mem_wdata = nxt[ValueWidth-1:0];
    case (state_q)
      BackIdle: begin
        if (job_valid_i) begin
          mem_we    = 1'b1;
          mem_waddr = '0;
          mem_wdata = FirstValue;
          pend_d    = FirstValue;
          lim_d     = job_i.lim;
          dp_d      = '0;
          tp_d      = '0;
          wi_d      = CntWidth'(1);
          if (job_i.single) begin
            strobe_d = 1'b1;
            value_d  = FirstValue;
            last_d   = 1'b1;
          end else begin
            state_d = BackRun;
          end
        end
      end
      BackRun: begin
        strobe_d = 1'b1;
        value_d  = pend_q;
        last_d   = stop;
        if (stop) begin
          state_d = BackIdle;
        end else begin
          mem_we = 1'b1;
          pend_d = nxt[ValueWidth-1:0];
          wi_d   = wi_q + 1'b1;
          if ({1'b0, cand2} == nxt) begin
            dp_d = dp_q + 1'b1;
          end
          if (cand3 == nxt) begin
            tp_d = tp_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = BackIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= BackIdle;
      dp_q     <= '0;
      tp_q     <= '0;
      wi_q     <= '0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      dp_q     <= dp_d;
      tp_q     <= tp_d;
      wi_q     <= wi_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q  <= pend_d;
    lim_q   <= lim_d;
    value_q <= value_d;
    last_q  <= last_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_q[mem_waddr] <= mem_wdata;
    end
    rd2_q <= (mem_we && (mem_waddr == dp_d)) ? mem_wdata : store_q[dp_d];
    rd3_q <= (mem_we && (mem_waddr == tp_d)) ? mem_wdata : store_q[tp_d];
  end

  assign value_o  = value_q;
  assign last_o   = last_q;
  assign strobe_o = strobe_q;

  `S23SG_ASSERT_NEXT(a_ascending, strobe_q && !last_q, strobe_q && (value_q > $past(value_q)), "sequence not ascending or broken")
  `S23SG_ASSERT_NEXT(a_single_one, job_pop_o && job_i.single, strobe_q && last_q && (value_q == FirstValue), "trivial request must give 1")
  `S23SG_ASSERT_SAME(a_pointers, state_q == BackRun, (CntWidth'(dp_q) < wi_q) && (CntWidth'(tp_q) < wi_q), "merge pointer beyond stored values")
  `S23SG_ASSERT_NEXT(a_first_run, job_pop_o && !job_i.single, !strobe_q ##1 (strobe_q && (value_q == FirstValue)), "sequence must open with 1")

endmodule

// File: verif/smooth_2p3q_sequence_generator_tb.sv
// Self-checking testbench for the 3-smooth sequence generator.
// It predicts every value and last flag in a local merge and compares them with the strobed outputs.
// Depends on s23sg_pkg and smooth_2p3q_sequence_generator.
module smooth_2p3q_sequence_generator_tb;
  import s23sg_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned StoreDepth = DefaultStoreDepth;
  localparam int unsigned NumRandom  = 158;

  typedef struct {
    logic [LimitWidth-1:0] limit;
    int unsigned           gap;
    bit                    drain;
  } limit_req_t;

  typedef struct {
    logic [ValueWidth-1:0] value;
    logic                  last;
  } smooth_val_t;

  logic                  clk_i   = 1'b0;
  logic                  rst_ni  = 1'b0;
  logic                  start   = 1'b0;
  logic                  busy;
  logic [LimitWidth-1:0] limit_i = '0;
  logic [ValueWidth-1:0] value_o;
  logic                  last_o;
  logic                  strobe_o;

  limit_req_t  pending_reqs[$];
  smooth_val_t due_values[$];
  limit_req_t  cur_req;
  logic        cur_loaded = 1'b0;
  logic        hold_start;
  int unsigned total_reqs = 0;
  int unsigned sent_reqs  = 0;
  int unsigned error_cnt  = 0;

  smooth_2p3q_sequence_generator #(
    .STORE_DEPTH(StoreDepth)
  ) i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .limit_i (limit_i),
    .value_o (value_o),
    .last_o  (last_o),
    .strobe_o(strobe_o)
  );

  always #4 clk_i = ~clk_i;

  task automatic push_smooth_sequence(input logic [LimitWidth-1:0] lim_in);
    logic [ValueWidth-1:0] store [StoreDepth];
    int unsigned           bound;
    int unsigned           two_idx;
    int unsigned           three_idx;
    int unsigned           fill;
    int unsigned           cand2;
    int unsigned           cand3;
    int unsigned           nxt;
    smooth_val_t           item;
    bound = 32'((lim_in > LimitCap) ? LimitCap : lim_in);
    store[0] = FirstValue;
    fill = 1;
    two_idx = 0;
    three_idx = 0;
    while (fill < StoreDepth) begin
      cand2 = 32'(store[two_idx]) * 2;
      cand3 = 32'(store[three_idx]) * 3;
      nxt = (cand2 <= cand3) ? cand2 : cand3;
      if (nxt >= bound) break;
      store[fill] = nxt[ValueWidth-1:0];
      fill++;
      if (cand2 == nxt) two_idx++;
      if (cand3 == nxt) three_idx++;
    end
    for (int k = 0; k < fill; k++) begin
      item.value = store[k];
      item.last = (k == fill - 1);
      due_values.push_back(item);
    end
  endtask

  task automatic add_request(input int unsigned lim, input int unsigned gap, input bit drain);
    limit_req_t req;
    req.limit = lim[LimitWidth-1:0];
    req.gap = gap;
    req.drain = drain;
    pending_reqs.push_back(req);
    total_reqs++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        push_smooth_sequence(limit_i);
        sent_reqs++;
      end
      hold_start = start && busy;
      if (!hold_start) begin
        if (!cur_loaded && pending_reqs.size() != 0) begin
          cur_req = pending_reqs.pop_front();
          cur_loaded = 1'b1;
        end
        if (cur_loaded) begin
          if (cur_req.gap != 0) begin
            cur_req.gap--;
          end else if (!cur_req.drain || due_values.size() == 0) begin
            hold_start = 1'b1;
            cur_loaded = 1'b0;
            limit_i <= cur_req.limit;
          end
        end
      end
      start <= hold_start;
    end
  end

  always @(posedge clk_i) begin
    smooth_val_t exp_item;
    if (rst_ni && strobe_o) begin
      if (due_values.size() == 0) begin
        $display("%0t: unexpected result value=%0d last=%0b", $time, value_o, last_o);
        error_cnt++;
      end else begin
        exp_item = due_values.pop_front();
        if (value_o !== exp_item.value) begin
          $display("%0t: value mismatch expected=%0d actual=%0d",
                   $time, exp_item.value, value_o);
          error_cnt++;
        end
        if (last_o !== exp_item.last) begin
          $display("%0t: last mismatch expected=%0b actual=%0b (value %0d)",
                   $time, exp_item.last, last_o, exp_item.value);
          error_cnt++;
        end
      end
    end
  end

  initial begin
    int unsigned sel;
    int unsigned lim_pick;
    bit          burst;
    burst = 1'b0;
    add_request(0, 0, 1'b0);
    add_request(1, 0, 1'b0);
    add_request(2, 0, 1'b0);
    add_request(3, 0, 1'b0);
    add_request(4, 2, 1'b0);
    add_request(5, 0, 1'b0);
    add_request(6, 0, 1'b0);
    add_request(7, 1, 1'b0);
    add_request(8, 0, 1'b0);
    add_request(9, 0, 1'b0);
    add_request(10, 3, 1'b0);
    add_request(4095, 0, 1'b0);
    add_request(4096, 0, 1'b1);
    add_request(4097, 0, 1'b0);
    add_request(8191, 5, 1'b0);
    add_request(13'h1555, 0, 1'b0);
    add_request(13'h0AAA, 0, 1'b0);
    add_request(3072, 0, 1'b0);
    add_request(3073, 0, 1'b0);
    add_request(97, 0, 1'b0);
    add_request(0, 0, 1'b0);
    add_request(2049, 14, 1'b0);
    for (int i = 0; i < NumRandom; i++) begin
      if (i % 20 == 0) burst = ($urandom_range(0, 3) == 0);
      sel = $urandom_range(0, 7);
      case (sel)
        0: lim_pick = $urandom_range(0, 10);
        1: lim_pick = $urandom_range(4097, 8191);
        2: lim_pick = $urandom_range(4090, 4096);
        default: lim_pick = $urandom_range(0, 4096);
      endcase
      add_request(lim_pick, burst ? 0 : $urandom_range(0, 14), $urandom_range(0, 29) == 0);
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (sent_reqs != total_reqs) @(posedge clk_i);
    while (due_values.size() != 0) @(posedge clk_i);
    repeat (64) @(posedge clk_i);

    if (error_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hdl
hdl/s23sg_pkg.sv
hdl/s23sg_front.sv
hdl/s23sg_queue.sv
hdl/s23sg_back.sv
hdl/smooth_2p3q_sequence_generator.sv
verif/smooth_2p3q_sequence_generator_tb.sv
